[sv/xcrc_rx_pkg.sv]
// ----------------------------------------------------------------------------
// XMODEM-CRC receiver package
// Protocol characters, verdict codes, packet geometry and the CRC-16 update.
// ----------------------------------------------------------------------------
package xcrc_rx_pkg;

  // Packet geometry.
  localparam int unsigned DATA_BYTES       = 128;
  localparam int unsigned PACKETS_PER_PAGE = 8;
  localparam int unsigned PAGE_BYTES       = DATA_BYTES * PACKETS_PER_PAGE;

  // Byte position within a packet: 0 awaits the header, 1 number, 2 complement,
  // 3 .. DATA_BYTES+2 payload, then the two CRC bytes.
  localparam int unsigned POS_W      = $clog2(DATA_BYTES + 5);
  localparam int unsigned POS_DATA   = 3;
  localparam int unsigned POS_CRC_HI = DATA_BYTES + 3;
  localparam int unsigned FILL_W     = $clog2(PACKETS_PER_PAGE + 1);

  // Field widths of one result.
  localparam int unsigned OFFSET_W = 10;
  localparam int unsigned COUNT_W  = 4;

  // Input opcodes.
  localparam logic OP_BYTE  = 1'b0;
  localparam logic OP_START = 1'b1;

  // Result kinds.
  localparam logic KIND_DATA    = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  // Protocol characters.
  localparam logic [7:0] CH_SOH  = 8'h01;
  localparam logic [7:0] CH_EOT  = 8'h04;
  localparam logic [7:0] CH_ACK  = 8'h06;
  localparam logic [7:0] CH_NAK  = 8'h15;
  localparam logic [7:0] CH_CAN  = 8'h18;
  localparam logic [7:0] CH_POLL = 8'h43;

  // Verdict status codes.
  localparam logic [2:0] ST_ACCEPTED   = 3'd0;
  localparam logic [2:0] ST_HEADER     = 3'd1;
  localparam logic [2:0] ST_COMPLEMENT = 3'd2;
  localparam logic [2:0] ST_DUPLICATE  = 3'd3;
  localparam logic [2:0] ST_ORDER      = 3'd4;
  localparam logic [2:0] ST_CRC        = 3'd5;
  localparam logic [2:0] ST_EOT        = 3'd6;
  localparam logic [2:0] ST_POLL       = 3'd7;

  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_INIT = 16'h0000;

  // Fields of one result item.
  typedef struct packed {
    logic                kind;
    logic [7:0]          data_byte;
    logic [OFFSET_W-1:0] write_offset;
    logic [7:0]          response_byte;
    logic [2:0]          status;
    logic                page_write;
    logic [31:0]         page_address;
    logic [COUNT_W-1:0]  packets_in_page;
    logic                stopped;
  } result_t;

  // CRC-16/XMODEM update by one byte, MSB first.
  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

[sv/xmodem_crc_packet_receiver.sv]
// ----------------------------------------------------------------------------
// XMODEM-CRC packet receiver
// Parses XMODEM-CRC packets one byte per transfer and reports data writes and
// per-packet verdicts with page write requests.
// ----------------------------------------------------------------------------
// Usage:
// Each slave transfer carries one received serial byte (tdata) together with
// an opcode and a start-of-frame flag (tuser). A start command clears the
// session and produces a poll verdict ('C'). Payload bytes produce tentative
// data write results (kind 0) with their offset in the page buffer; the last
// CRC byte of a packet produces one verdict (kind 1) with the response byte
// to send back, and a page write request with its flash address when a page
// fills up or EOT closes a partly filled page. A bad header and EOT produce a
// verdict too; SOH, number, complement and the first CRC byte produce none.
// Every transfer is processed in the cycle it is accepted: the parser state
// and the CRC update by one byte are combinational between the state
// registers and the output register, so a result appears on the master side
// in the cycle after its input transfer; one transfer a cycle unless stalled.
// The output register holds a result until it is taken; while it holds a
// result the slave side stays ready only if the receiver takes it in the same
// cycle, so a stalled receiver back-pressures the input after one result.
// Reset clears the session and sets flash_base to zero; cfg_we_i writes it.
// ----------------------------------------------------------------------------
module xmodem_crc_packet_receiver (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration: flash_base.
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  // Input bytes.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  input  logic [1:0]  s_axis_tuser_i,   // [0] opcode, [1] frame_first
  // Results.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [7:0] data_byte, [17:8] write_offset, [25:18] response_byte,
  // [28:26] status, [29] page_write, [61:30] page_address,
  // [65:62] packets_in_page, [66] stopped, [71:67] zero
  output logic [71:0] m_axis_tdata_o,
  output logic        m_axis_tuser_o    // [0] kind
);

  localparam int unsigned PosW  = xcrc_rx_pkg::POS_W;
  localparam int unsigned FillW = xcrc_rx_pkg::FILL_W;

  // Session state.
  logic [31:0]      flash_base_q;
  logic [PosW-1:0]  pos_q, pos_d;
  logic [7:0]       expected_q, expected_d;
  logic [7:0]       number_q, number_d;
  logic [7:0]       compl_q, compl_d;
  logic [15:0]      crc_q, crc_d;
  logic [7:0]       crc_hi_q, crc_hi_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic [15:0]      page_idx_q, page_idx_d;
  logic             stopped_q, stopped_d;

  // Output register.
  logic                   out_valid_q;
  xcrc_rx_pkg::result_t   out_q;

  logic                   accept;
  logic                   res_valid;
  xcrc_rx_pkg::result_t   res;

  logic                   op;
  logic                   first;
  logic [7:0]             rx;
  logic [31:0]            page_addr;
  logic [FillW-1:0]       fill_inc;
  logic [xcrc_rx_pkg::OFFSET_W-1:0] data_offset;

  assign op    = s_axis_tuser_i[0];
  assign first = s_axis_tuser_i[1];
  assign rx    = s_axis_tdata_i;

  // A new transfer is taken whenever the output register is free or drains now.
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  assign page_addr = flash_base_q
                   + 32'(xcrc_rx_pkg::PAGE_BYTES) * {16'h0000, page_idx_q};
  assign fill_inc  = fill_q + FillW'(1);
  assign data_offset = xcrc_rx_pkg::OFFSET_W'(
                         32'(fill_q) * 32'(xcrc_rx_pkg::DATA_BYTES)
                       + 32'(pos_q) - 32'(xcrc_rx_pkg::POS_DATA));

  // Parser: next state and the result of the current byte.
  always_comb begin
    pos_d      = pos_q;
    expected_d = expected_q;
    number_d   = number_q;
    compl_d    = compl_q;
    crc_d      = crc_q;
    crc_hi_d   = crc_hi_q;
    fill_d     = fill_q;
    page_idx_d = page_idx_q;
    stopped_d  = stopped_q;

    res_valid = 1'b0;
    res       = '0;
    res.kind  = xcrc_rx_pkg::KIND_VERDICT;

    if (op == xcrc_rx_pkg::OP_START) begin
      pos_d      = '0;
      expected_d = 8'd1;
      number_d   = 8'h00;
      compl_d    = 8'h00;
      crc_d      = xcrc_rx_pkg::CRC_INIT;
      crc_hi_d   = 8'h00;
      fill_d     = '0;
      page_idx_d = 16'h0000;
      stopped_d  = 1'b0;
      res_valid  = 1'b1;
      res.response_byte = xcrc_rx_pkg::CH_POLL;
      res.status        = xcrc_rx_pkg::ST_POLL;
    end else if (!stopped_q) begin
      if (first) begin
        // A new frame always restarts the packet, even in mid-packet.
        pos_d = '0;
        if (rx == xcrc_rx_pkg::CH_EOT) begin
          stopped_d         = 1'b1;
          res_valid         = 1'b1;
          res.response_byte = xcrc_rx_pkg::CH_ACK;
          res.status        = xcrc_rx_pkg::ST_EOT;
          if (fill_q != '0) begin
            res.page_write   = 1'b1;
            res.page_address = page_addr;
          end
        end else if (rx != xcrc_rx_pkg::CH_SOH) begin
          res_valid         = 1'b1;
          res.response_byte = xcrc_rx_pkg::CH_NAK;
          res.status        = xcrc_rx_pkg::ST_HEADER;
        end else begin
          pos_d = PosW'(1);
        end
      end else if (pos_q == PosW'(1)) begin
        number_d = rx;
        pos_d    = PosW'(2);
      end else if (pos_q == PosW'(2)) begin
        compl_d = rx;
        crc_d   = xcrc_rx_pkg::CRC_INIT;
        pos_d   = PosW'(xcrc_rx_pkg::POS_DATA);
      end else if (pos_q != '0 && pos_q < PosW'(xcrc_rx_pkg::POS_CRC_HI)) begin
        crc_d     = xcrc_rx_pkg::crc_update(crc_q, rx);
        pos_d     = pos_q + PosW'(1);
        res_valid = 1'b1;
        res.kind         = xcrc_rx_pkg::KIND_DATA;
        res.data_byte    = rx;
        res.write_offset = data_offset;
      end else if (pos_q == PosW'(xcrc_rx_pkg::POS_CRC_HI)) begin
        crc_hi_d = rx;
        pos_d    = pos_q + PosW'(1);
      end else if (pos_q != '0) begin
        // Last CRC byte: judge the packet.
        pos_d     = '0;
        res_valid = 1'b1;
        if ((number_q ^ compl_q) != 8'hFF) begin
          res.response_byte = xcrc_rx_pkg::CH_NAK;
          res.status        = xcrc_rx_pkg::ST_COMPLEMENT;
        end else if (number_q != expected_q) begin
          if (number_q == expected_q - 8'd1) begin
            res.response_byte = xcrc_rx_pkg::CH_ACK;
            res.status        = xcrc_rx_pkg::ST_DUPLICATE;
          end else begin
            stopped_d         = 1'b1;
            res.response_byte = xcrc_rx_pkg::CH_CAN;
            res.status        = xcrc_rx_pkg::ST_ORDER;
          end
        end else if ({crc_hi_q, rx} != crc_q) begin
          res.response_byte = xcrc_rx_pkg::CH_NAK;
          res.status        = xcrc_rx_pkg::ST_CRC;
        end else begin
          expected_d        = expected_q + 8'd1;
          res.response_byte = xcrc_rx_pkg::CH_ACK;
          res.status        = xcrc_rx_pkg::ST_ACCEPTED;
          if (fill_inc >= FillW'(xcrc_rx_pkg::PACKETS_PER_PAGE)) begin
            fill_d           = '0;
            page_idx_d       = page_idx_q + 16'd1;
            res.page_write   = 1'b1;
            res.page_address = page_addr;
          end else begin
            fill_d = fill_inc;
          end
        end
      end
    end

    // The count reports the written page's packets, else the fill after the byte.
    if (res.page_write && res.status == xcrc_rx_pkg::ST_ACCEPTED) begin
      res.packets_in_page = xcrc_rx_pkg::COUNT_W'(xcrc_rx_pkg::PACKETS_PER_PAGE);
    end else if (res.kind == xcrc_rx_pkg::KIND_DATA) begin
      res.packets_in_page = xcrc_rx_pkg::COUNT_W'(fill_q);
    end else begin
      res.packets_in_page = xcrc_rx_pkg::COUNT_W'(fill_d);
    end
    res.stopped = stopped_d;
  end

  // State registers advance on every accepted transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flash_base_q <= 32'h0000_0000;
      pos_q        <= '0;
      expected_q   <= 8'd1;
      number_q     <= 8'h00;
      compl_q      <= 8'h00;
      crc_q        <= xcrc_rx_pkg::CRC_INIT;
      crc_hi_q     <= 8'h00;
      fill_q       <= '0;
      page_idx_q   <= 16'h0000;
      stopped_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        flash_base_q <= cfg_wdata_i;
      end
      if (accept) begin
        pos_q      <= pos_d;
        expected_q <= expected_d;
        number_q   <= number_d;
        compl_q    <= compl_d;
        crc_q      <= crc_d;
        crc_hi_q   <= crc_hi_d;
        fill_q     <= fill_d;
        page_idx_q <= page_idx_d;
        stopped_q  <= stopped_d;
      end
    end
  end

  // Output register: loaded by a result, cleared when taken without a new one.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_q.kind;
  assign m_axis_tdata_o  = {5'b00000,
                            out_q.stopped,
                            out_q.packets_in_page,
                            out_q.page_address,
                            out_q.page_write,
                            out_q.status,
                            out_q.response_byte,
                            out_q.write_offset,
                            out_q.data_byte};

endmodule

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// Testbench for the XMODEM-CRC packet receiver
// Streams serial bytes and start commands into the receiver, predicts every
// data write and packet verdict with a cycle-free model of the parser, and
// compares each result transfer field by field under random back-pressure.
// ----------------------------------------------------------------------------
module tb_top;

  // One whole packet on the wire: SOH, number, complement, payload, CRC.
  localparam int unsigned FRAME_LEN   = xcrc_rx_pkg::DATA_BYTES + 5;
  // Random bytes per phase; the count skips bytes that a stopped session drops.
  localparam int unsigned PHASE_ITEMS = 420;
  // Cycles without any transfer before the run is declared hung.
  localparam int unsigned STALL_LIMIT = 2000;

  // One input transfer as the sender sees it.
  typedef struct packed {
    logic       opcode;
    logic [7:0] rx;
    logic       first;
  } rx_item_t;

  // Parser and session state of the receiver, plus its flash base register.
  typedef struct {
    int unsigned pos;
    logic [7:0]  next_num;
    logic [7:0]  num;
    logic [7:0]  cmpl;
    logic [15:0] crc;
    logic [7:0]  crc_hi;
    int unsigned fill;
    logic [15:0] page_idx;
    logic        stopped;
    logic [31:0] base;
  } rx_state_t;

  // Kinds of traffic that the random part strings together.
  typedef enum int {
    SC_GOOD, SC_DUP, SC_CRC, SC_COMPL, SC_ORDER,
    SC_CUT, SC_HEADER, SC_EOT, SC_START, SC_NOISE
  } scenario_e;

  logic        clk_i;
  logic        rst_ni          = 1'b0;
  logic        cfg_we_i        = 1'b0;
  logic [31:0] cfg_wdata_i     = '0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i  = '0;
  logic [1:0]  s_axis_tuser_i  = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [71:0] m_axis_tdata_o;
  logic        m_axis_tuser_o;

  // Two copies of the receiver state: one follows the accepted transfers and
  // predicts results, the other follows the stimulus as it is queued so that
  // the generator knows the next block number and whether the session stopped.
  rx_state_t   rx_mirror;
  rx_state_t   stim_mirror;

  rx_item_t               pending_bytes[$];
  xcrc_rx_pkg::result_t   expected_results[$];
  rx_item_t               in_flight;
  xcrc_rx_pkg::result_t   predicted;

  int unsigned sender_idle_pct = 0;
  int unsigned ready_stall_pct = 0;
  int unsigned stim_count      = 0;
  int unsigned fail_count      = 0;
  int unsigned stall_cycles    = 0;

  xmodem_crc_packet_receiver uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // CRC-16/XMODEM, shifted one message bit at a time through the register.
  function automatic logic [15:0] crc16_shift(input logic [15:0] crc,
                                              input logic [7:0] b);
    logic [15:0] r;
    logic        fb;
    r = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[15] ^ b[i];
      r  = {r[14:0], 1'b0} ^ (fb ? xcrc_rx_pkg::CRC_POLY : 16'h0000);
    end
    return r;
  endfunction

  // A start command and reset both begin a fresh session; a start keeps flash base.
  function automatic void clear_session(inout rx_state_t st);
    st.pos      = 0;
    st.next_num = 8'd1;
    st.num      = '0;
    st.cmpl     = '0;
    st.crc      = xcrc_rx_pkg::CRC_INIT;
    st.crc_hi   = '0;
    st.fill     = 0;
    st.page_idx = '0;
    st.stopped  = 1'b0;
  endfunction

  function automatic logic [31:0] page_base_addr(input rx_state_t st);
    return st.base + 32'(xcrc_rx_pkg::PAGE_BYTES) * 32'(st.page_idx);
  endfunction

  function automatic xcrc_rx_pkg::result_t verdict_of(input logic [7:0] resp,
                                                      input logic [2:0] status,
                                                      input logic pw,
                                                      input logic [31:0] addr,
                                                      input int unsigned count,
                                                      input logic stopped);
    xcrc_rx_pkg::result_t r;
    r                 = '0;
    r.kind            = xcrc_rx_pkg::KIND_VERDICT;
    r.response_byte   = resp;
    r.status          = status;
    r.page_write      = pw;
    r.page_address    = pw ? addr : '0;
    r.packets_in_page = xcrc_rx_pkg::COUNT_W'(count);
    r.stopped         = stopped;
    return r;
  endfunction

  // Advances the receiver state by one input transfer. Returns 1 when the
  // transfer produces a result, which is then left in res.
  function automatic bit xmodem_rx_step(inout rx_state_t st, input rx_item_t it,
                                        output xcrc_rx_pkg::result_t res);
    int unsigned off;
    logic [7:0]  prev_num;
    logic [31:0] addr;
    res = '0;
    if (it.opcode == xcrc_rx_pkg::OP_START) begin
      clear_session(st);
      res = verdict_of(xcrc_rx_pkg::CH_POLL, xcrc_rx_pkg::ST_POLL, 1'b0, '0,
                       st.fill, st.stopped);
      return 1'b1;
    end
    // A cancelled or finished session drops everything until the next start.
    if (st.stopped) begin
      return 1'b0;
    end
    // A frame start always restarts the parser, even in mid-packet.
    if (it.first) begin
      st.pos = 0;
      if (it.rx == xcrc_rx_pkg::CH_EOT) begin
        st.stopped = 1'b1;
        res = verdict_of(xcrc_rx_pkg::CH_ACK, xcrc_rx_pkg::ST_EOT, st.fill != 0,
                         page_base_addr(st), st.fill, 1'b1);
        return 1'b1;
      end
      if (it.rx != xcrc_rx_pkg::CH_SOH) begin
        res = verdict_of(xcrc_rx_pkg::CH_NAK, xcrc_rx_pkg::ST_HEADER, 1'b0, '0,
                         st.fill, st.stopped);
        return 1'b1;
      end
      st.pos = 1;
      return 1'b0;
    end
    if (st.pos == 0) begin
      return 1'b0;
    end
    if (st.pos == 1) begin
      st.num = it.rx;
      st.pos = 2;
      return 1'b0;
    end
    if (st.pos == 2) begin
      st.cmpl = it.rx;
      st.crc  = xcrc_rx_pkg::CRC_INIT;
      st.pos  = xcrc_rx_pkg::POS_DATA;
      return 1'b0;
    end
    if (st.pos < xcrc_rx_pkg::POS_CRC_HI) begin
      off                 = st.fill * xcrc_rx_pkg::DATA_BYTES
                          + (st.pos - xcrc_rx_pkg::POS_DATA);
      st.crc              = crc16_shift(st.crc, it.rx);
      st.pos              = st.pos + 1;
      res.kind            = xcrc_rx_pkg::KIND_DATA;
      res.data_byte       = it.rx;
      res.write_offset    = xcrc_rx_pkg::OFFSET_W'(off);
      res.packets_in_page = xcrc_rx_pkg::COUNT_W'(st.fill);
      res.stopped         = st.stopped;
      return 1'b1;
    end
    if (st.pos == xcrc_rx_pkg::POS_CRC_HI) begin
      st.crc_hi = it.rx;
      st.pos    = st.pos + 1;
      return 1'b0;
    end
    // Low CRC byte: the packet is judged as a whole.
    st.pos   = 0;
    prev_num = st.next_num - 8'd1;
    if ((st.num ^ st.cmpl) != 8'hFF) begin
      res = verdict_of(xcrc_rx_pkg::CH_NAK, xcrc_rx_pkg::ST_COMPLEMENT, 1'b0, '0,
                       st.fill, st.stopped);
    end else if (st.num == prev_num && st.num != st.next_num) begin
      res = verdict_of(xcrc_rx_pkg::CH_ACK, xcrc_rx_pkg::ST_DUPLICATE, 1'b0, '0,
                       st.fill, st.stopped);
    end else if (st.num != st.next_num) begin
      st.stopped = 1'b1;
      res = verdict_of(xcrc_rx_pkg::CH_CAN, xcrc_rx_pkg::ST_ORDER, 1'b0, '0,
                       st.fill, st.stopped);
    end else if ({st.crc_hi, it.rx} != st.crc) begin
      res = verdict_of(xcrc_rx_pkg::CH_NAK, xcrc_rx_pkg::ST_CRC, 1'b0, '0,
                       st.fill, st.stopped);
    end else begin
      st.next_num = st.next_num + 8'd1;
      st.fill     = st.fill + 1;
      if (st.fill >= xcrc_rx_pkg::PACKETS_PER_PAGE) begin
        addr        = page_base_addr(st);
        st.fill     = 0;
        st.page_idx = st.page_idx + 16'd1;
        res = verdict_of(xcrc_rx_pkg::CH_ACK, xcrc_rx_pkg::ST_ACCEPTED, 1'b1, addr,
                         xcrc_rx_pkg::PACKETS_PER_PAGE, st.stopped);
      end else begin
        res = verdict_of(xcrc_rx_pkg::CH_ACK, xcrc_rx_pkg::ST_ACCEPTED, 1'b0, '0,
                         st.fill, st.stopped);
      end
    end
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------

  // Queues one transfer and lets the stimulus copy of the state follow it.
  task automatic emit(input logic op, input logic [7:0] b, input logic first);
    rx_item_t             it;
    xcrc_rx_pkg::result_t unused;
    it.opcode = op;
    it.rx     = b;
    it.first  = first;
    if (!stim_mirror.stopped) begin
      stim_count++;
    end
    void'(xmodem_rx_step(stim_mirror, it, unused));
    pending_bytes.push_back(it);
  endtask

  // Sends the first keep bytes of a packet. A nonzero crc_err corrupts the
  // trailing CRC; keep below FRAME_LEN leaves the packet cut short.
  task automatic send_packet(input logic [7:0] num, input logic [7:0] cmpl,
                             input logic [15:0] crc_err, input int unsigned keep);
    logic [7:0]  frame [FRAME_LEN];
    logic [15:0] crc;
    int unsigned fill_mode;
    fill_mode = $urandom_range(0, 9);
    frame[0]  = xcrc_rx_pkg::CH_SOH;
    frame[1]  = num;
    frame[2]  = cmpl;
    crc       = xcrc_rx_pkg::CRC_INIT;
    for (int i = 0; i < xcrc_rx_pkg::DATA_BYTES; i++) begin
      // Now and then a payload of all zeros or all ones.
      case (fill_mode)
        0:       frame[xcrc_rx_pkg::POS_DATA + i] = 8'h00;
        1:       frame[xcrc_rx_pkg::POS_DATA + i] = 8'hFF;
        default: frame[xcrc_rx_pkg::POS_DATA + i] = 8'($urandom);
      endcase
      crc = crc16_shift(crc, frame[xcrc_rx_pkg::POS_DATA + i]);
    end
    crc                                = crc ^ crc_err;
    frame[xcrc_rx_pkg::POS_CRC_HI]     = crc[15:8];
    frame[xcrc_rx_pkg::POS_CRC_HI + 1] = crc[7:0];
    for (int i = 0; i < keep; i++) begin
      emit(xcrc_rx_pkg::OP_BYTE, frame[i], i == 0);
    end
  endtask

  function automatic scenario_e pick_scenario();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return SC_GOOD;
    if (r < 72) return SC_DUP;
    if (r < 77) return SC_CRC;
    if (r < 82) return SC_COMPL;
    if (r < 85) return SC_ORDER;
    if (r < 90) return SC_CUT;
    if (r < 93) return SC_HEADER;
    if (r < 95) return SC_EOT;
    if (r < 96) return SC_START;
    return SC_NOISE;
  endfunction

  task automatic run_scenario(input scenario_e sc);
    logic [7:0] n;
    logic [7:0] b;
    // A stopped session first sees up to two dropped bytes, then a start command.
    if (stim_mirror.stopped) begin
      repeat ($urandom_range(0, 2)) begin
        emit(xcrc_rx_pkg::OP_BYTE, 8'($urandom), 1'($urandom));
      end
      emit(xcrc_rx_pkg::OP_START, 8'($urandom), 1'($urandom));
    end
    n = stim_mirror.next_num;
    case (sc)
      SC_GOOD:  send_packet(n, ~n, 16'h0000, FRAME_LEN);
      SC_DUP: begin
        n = n - 8'd1;
        send_packet(n, ~n, 16'h0000, FRAME_LEN);
      end
      SC_CRC:   send_packet(n, ~n, 16'($urandom_range(1, 16'hFFFF)), FRAME_LEN);
      SC_COMPL: begin
        if ($urandom_range(0, 1)) begin
          n = 8'($urandom);
        end
        send_packet(n, ~n ^ 8'($urandom_range(1, 255)), 16'h0000, FRAME_LEN);
      end
      SC_ORDER: begin
        do begin
          n = 8'($urandom);
        end while (n == stim_mirror.next_num || n == stim_mirror.next_num - 8'd1);
        send_packet(n, ~n, 16'h0000, FRAME_LEN);
      end
      // Unless it is noise, the next scenario restarts the parser and abandons this packet.
      SC_CUT:   send_packet(n, ~n, 16'h0000, $urandom_range(1, FRAME_LEN - 1));
      SC_HEADER: begin
        do begin
          b = 8'($urandom);
        end while (b == xcrc_rx_pkg::CH_SOH || b == xcrc_rx_pkg::CH_EOT);
        emit(xcrc_rx_pkg::OP_BYTE, b, 1'b1);
        repeat ($urandom_range(0, 5)) begin
          emit(xcrc_rx_pkg::OP_BYTE, 8'($urandom), 1'b0);
        end
      end
      SC_EOT:   emit(xcrc_rx_pkg::OP_BYTE, xcrc_rx_pkg::CH_EOT, 1'b1);
      SC_START: emit(xcrc_rx_pkg::OP_START, 8'($urandom), 1'($urandom));
      default: begin
        repeat ($urandom_range(1, 4)) begin
          emit(($urandom_range(0, 19) == 0) ? xcrc_rx_pkg::OP_START
                                            : xcrc_rx_pkg::OP_BYTE,
               8'($urandom), $urandom_range(0, 3) == 0);
        end
      end
    endcase
  endtask

  // Short hand-picked sequence: poll, stray and bad headers, a packet cut
  // short, EOT on an empty page, a dropped byte after EOT and a start command
  // that lands in the middle of a packet.
  task automatic run_directed();
    emit(xcrc_rx_pkg::OP_START, 8'h00, 1'b0);
    emit(xcrc_rx_pkg::OP_BYTE, 8'h55, 1'b0);
    emit(xcrc_rx_pkg::OP_BYTE, 8'h00, 1'b1);
    emit(xcrc_rx_pkg::OP_BYTE, 8'hFF, 1'b0);
    emit(xcrc_rx_pkg::OP_BYTE, 8'hFF, 1'b1);
    emit(xcrc_rx_pkg::OP_BYTE, xcrc_rx_pkg::CH_SOH, 1'b1);
    emit(xcrc_rx_pkg::OP_BYTE, 8'h01, 1'b0);
    emit(xcrc_rx_pkg::OP_BYTE, xcrc_rx_pkg::CH_SOH, 1'b1);
    emit(xcrc_rx_pkg::OP_BYTE, 8'h01, 1'b0);
    emit(xcrc_rx_pkg::OP_BYTE, 8'hFE, 1'b0);
    emit(xcrc_rx_pkg::OP_BYTE, 8'hAA, 1'b0);
    emit(xcrc_rx_pkg::OP_BYTE, 8'h55, 1'b0);
    emit(xcrc_rx_pkg::OP_BYTE, xcrc_rx_pkg::CH_EOT, 1'b1);
    emit(xcrc_rx_pkg::OP_BYTE, xcrc_rx_pkg::CH_SOH, 1'b1);
    emit(xcrc_rx_pkg::OP_START, 8'hFF, 1'b1);
    emit(xcrc_rx_pkg::OP_BYTE, xcrc_rx_pkg::CH_SOH, 1'b1);
    emit(xcrc_rx_pkg::OP_BYTE, 8'h01, 1'b0);
    emit(xcrc_rx_pkg::OP_START, 8'h80, 1'b0);
  endtask

  // Holds off until the sender has nothing left and every predicted result
  // has been taken, then lets the output register settle.
  task automatic wait_drained();
    while (pending_bytes.size() != 0 || s_axis_tvalid_i || expected_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_flash_base(input logic [31:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    rx_mirror.base   = value;
    stim_mirror.base = value;
  endtask

  // --------------------------------------------------------------------------
  // Sequencing: three phases with different idling, each after a flash base
  // write on an idle block. Each drain makes the sender pause until every
  // predicted result has come back.
  // --------------------------------------------------------------------------
  initial begin
    clear_session(rx_mirror);
    clear_session(stim_mirror);
    rx_mirror.base   = '0;
    stim_mirror.base = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          sender_idle_pct = 30;
          ready_stall_pct = 65;
          write_flash_base(32'hFFFF_FFFF);
        end
        1: begin
          sender_idle_pct = 65;
          ready_stall_pct = 30;
          write_flash_base(32'h0000_0000);
        end
        default: begin
          sender_idle_pct = 0;
          ready_stall_pct = 0;
          write_flash_base($urandom);
        end
      endcase
      stim_count = 0;
      if (ph == 0) begin
        run_directed();
        // Every kind of packet outcome once before the random mix.
        for (int k = 0; k <= SC_NOISE; k++) begin
          run_scenario(scenario_e'(k));
        end
      end
      while (stim_count < PHASE_ITEMS) begin
        run_scenario(pick_scenario());
      end
      wait_drained();
    end
    if (fail_count == 0) begin
      $display("xmodem_crc_packet_receiver verification clean");
    end else begin
      $display("xmodem_crc_packet_receiver verification failed");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Driver: a transfer taken at this edge is run through the predictor, then
  // the next queued byte is presented unless the sender idles this cycle.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        if (xmodem_rx_step(rx_mirror, in_flight, predicted)) begin
          expected_results.push_back(predicted);
        end
      end
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          in_flight = pending_bytes.pop_front();
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i  <= in_flight.rx;
          s_axis_tuser_i  <= {in_flight.first, in_flight.opcode};
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: every result transfer is matched against the oldest prediction.
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  task automatic check_result();
    xcrc_rx_pkg::result_t got;
    xcrc_rx_pkg::result_t want;
    got.kind            = m_axis_tuser_o;
    got.data_byte       = m_axis_tdata_o[7:0];
    got.write_offset    = m_axis_tdata_o[17:8];
    got.response_byte   = m_axis_tdata_o[25:18];
    got.status          = m_axis_tdata_o[28:26];
    got.page_write      = m_axis_tdata_o[29];
    got.page_address    = m_axis_tdata_o[61:30];
    got.packets_in_page = m_axis_tdata_o[65:62];
    got.stopped         = m_axis_tdata_o[66];
    if (expected_results.size() == 0) begin
      $error("result transfer with no prediction pending (kind %0d)", got.kind);
      fail_count++;
    end else begin
      want = expected_results.pop_front();
      check_field("kind", 32'(want.kind), 32'(got.kind));
      check_field("data_byte", 32'(want.data_byte), 32'(got.data_byte));
      check_field("write_offset", 32'(want.write_offset), 32'(got.write_offset));
      check_field("response_byte", 32'(want.response_byte), 32'(got.response_byte));
      check_field("status", 32'(want.status), 32'(got.status));
      check_field("page_write", 32'(want.page_write), 32'(got.page_write));
      check_field("page_address", want.page_address, got.page_address);
      check_field("packets_in_page", 32'(want.packets_in_page),
                  32'(got.packets_in_page));
      check_field("stopped", 32'(want.stopped), 32'(got.stopped));
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        check_result();
      end
      m_axis_tready_i <= ($urandom_range(0, 99) >= ready_stall_pct);
    end
  end

  // Watchdog: the run is hung once no transfer moves on either side for too
  // long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("xmodem_crc_packet_receiver verification failed");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

endmodule
